FILE: src/kda_pkg.sv
// Package for the key debounce and auto-repeat block.
// Holds register indexes, key patterns, event codes and shared types; no dependencies.
package kda_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam int unsigned CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RAMP_START       = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RAMP_END         = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RAMP_STEP        = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEBOUNCE_PERIODS = 8'd3;

   localparam logic [7:0] RAMP_START_RESET       = 8'd80;
   localparam logic [7:0] RAMP_END_RESET         = 8'd16;
   localparam logic [7:0] RAMP_STEP_RESET        = 8'd8;
   localparam logic [7:0] DEBOUNCE_PERIODS_RESET = 8'd5;

   localparam logic [3:0] PAT_NO_KEY   = 4'h0F;
   localparam logic [3:0] PAT_FN_KEY   = 4'h0D;
   localparam logic [3:0] PAT_DOWN_KEY = 4'h07;
   localparam logic [3:0] PAT_UP_KEY   = 4'h0B;
   localparam logic [3:0] PAT_RELEASE  = 4'h02;

   localparam logic [3:0] EDGE_DOWN    = 4'h08;
   localparam logic [3:0] EDGE_UP      = 4'h04;
   localparam logic [3:0] EDGE_RELEASE = 4'h02;
   localparam logic [3:0] EDGE_CLEAN   = 4'h01;

   localparam logic [2:0] PHASE_START = 3'd4;

   localparam logic [7:0] CODE_DOWN    = 8'h64;
   localparam logic [7:0] CODE_UP      = 8'h75;
   localparam logic [7:0] CODE_RELEASE = 8'h72;
   localparam logic [7:0] CODE_CLEAN   = 8'h6B;
   localparam logic [7:0] CODE_FUNC    = 8'h66;

   typedef struct packed {
      logic [7:0] ramp_start;
      logic [7:0] ramp_end;
      logic [7:0] ramp_step;
      logic [7:0] debounce_periods;
   } cfg_type;

   typedef struct packed {
      logic       event_written;
      logic [7:0] event_code;
      logic [3:0] keys_stable;
      logic       activity;
      logic       clean_request;
   } result_type;

endpackage

FILE: src/kda_scan.sv
// Scan step: sample shifting, debounce and auto-repeat ramp for one tick per beat.
// Depends on kda_pkg for configuration and result types.
module kda_scan import kda_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic       pin_level,
   input  cfg_type    cfg,
   output result_type result
);

   logic [3:0] sample_shift_ff, sample_shift_in;
   logic [2:0] scan_phase_ff, scan_phase_in;
   logic [3:0] last_pattern_ff, last_pattern_in;
   logic [7:0] debounce_count_ff, debounce_count_in;
   logic [3:0] stable_pattern_ff, stable_pattern_in;
   logic [7:0] repeat_count_ff, repeat_count_in;
   logic [7:0] repeat_reload_ff, repeat_reload_in;
   logic       long_press_ff, long_press_in;

   always_comb begin
      logic [2:0] phase_dec;
      logic [3:0] edge_mask;
      logic [8:0] grow_sum;
      logic [9:0] start_x3;
      logic [7:0] func_limit;
      sample_shift_in   = {pin_level, sample_shift_ff[3:1]};
      phase_dec         = scan_phase_ff - 3'd1;
      scan_phase_in     = phase_dec;
      last_pattern_in   = last_pattern_ff;
      debounce_count_in = debounce_count_ff;
      stable_pattern_in = stable_pattern_ff;
      repeat_count_in   = repeat_count_ff;
      repeat_reload_in  = repeat_reload_ff;
      long_press_in     = long_press_ff;
      edge_mask         = (stable_pattern_ff ^ sample_shift_in) & (stable_pattern_ff ^ PAT_RELEASE);
      grow_sum          = {1'b0, repeat_reload_ff} + {1'b0, cfg.ramp_step};
      start_x3          = {2'b00, cfg.ramp_start} + {1'b0, cfg.ramp_start, 1'b0};
      func_limit        = start_x3[9:2];
      result            = '0;
      if (phase_dec == 3'd0) begin
         scan_phase_in = PHASE_START;
         if (sample_shift_in != last_pattern_ff) begin
            debounce_count_in = cfg.debounce_periods;
            last_pattern_in   = sample_shift_in;
         end
         if (debounce_count_in != 8'd0) begin
            debounce_count_in = debounce_count_in - 8'd1;
            if (debounce_count_in == 8'd0) begin
               if (sample_shift_in != PAT_NO_KEY || stable_pattern_ff == PAT_FN_KEY) begin
                  result.event_written = 1'b1;
                  result.event_code    = {4'h0, edge_mask};
                  if (edge_mask == EDGE_DOWN) begin
                     result.event_code = CODE_DOWN;
                  end else if (edge_mask == EDGE_UP) begin
                     result.event_code = CODE_UP;
                  end else if (edge_mask == EDGE_RELEASE && !long_press_ff) begin
                     result.event_code = CODE_RELEASE;
                  end else if (edge_mask == EDGE_CLEAN) begin
                     result.event_code    = CODE_CLEAN;
                     result.clean_request = 1'b1;
                  end
               end
               if (stable_pattern_ff == PAT_NO_KEY) begin
                  long_press_in = 1'b0;
               end
               if (stable_pattern_ff != sample_shift_in) begin
                  repeat_count_in = cfg.ramp_start;
               end
               stable_pattern_in = sample_shift_in;
               result.activity   = 1'b1;
            end
         end
         if (repeat_count_in > cfg.ramp_end) begin
            repeat_count_in = repeat_count_in - 8'd1;
         end else begin
            repeat_count_in = repeat_reload_ff;
            if (stable_pattern_in == PAT_NO_KEY) begin
               if (repeat_reload_ff < cfg.ramp_start) begin
                  repeat_reload_in = grow_sum[8] ? 8'hFF : grow_sum[7:0];
               end
            end else begin
               if (repeat_reload_ff > cfg.ramp_end) begin
                  repeat_reload_in = (repeat_reload_ff >= cfg.ramp_step) ?
                                     repeat_reload_ff - cfg.ramp_step : 8'd0;
               end
               if (stable_pattern_in == PAT_DOWN_KEY) begin
                  result.event_code    = CODE_DOWN;
                  result.event_written = 1'b1;
               end
               if (stable_pattern_in == PAT_UP_KEY) begin
                  result.event_code    = CODE_UP;
                  result.event_written = 1'b1;
               end
               if (stable_pattern_in == PAT_FN_KEY && repeat_reload_in < func_limit) begin
                  result.event_code    = CODE_FUNC;
                  result.event_written = 1'b1;
                  repeat_reload_in     = cfg.ramp_start;
                  long_press_in        = 1'b1;
               end
               result.activity = 1'b1;
            end
         end
      end
      result.keys_stable = stable_pattern_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_shift_ff   <= '0;
         scan_phase_ff     <= PHASE_START;
         last_pattern_ff   <= '0;
         debounce_count_ff <= '0;
         stable_pattern_ff <= PAT_NO_KEY;
         repeat_count_ff   <= RAMP_START_RESET;
         repeat_reload_ff  <= RAMP_START_RESET;
         long_press_ff     <= 1'b0;
      end else if (step_en) begin
         sample_shift_ff   <= sample_shift_in;
         scan_phase_ff     <= scan_phase_in;
         last_pattern_ff   <= last_pattern_in;
         debounce_count_ff <= debounce_count_in;
         stable_pattern_ff <= stable_pattern_in;
         repeat_count_ff   <= repeat_count_in;
         repeat_reload_ff  <= repeat_reload_in;
         long_press_ff     <= long_press_in;
      end
   end

endmodule

FILE: src/key_debounce_autorepeat.sv
// Each accepted tick beat's result is registered in the output or skid register.
// Throughput: one tick per cycle unless req_stall; a two-entry output stage
// (register plus skid) accepts one more beat while a result waits on rsp_stall.
// Reset (synchronous, active high): registers back to defaults, phase 4,
// stable pattern no-key, ramp at its start value, output stage empty.
module key_debounce_autorepeat import kda_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_pin_level,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_event_written,
   output logic [7:0]                 rsp_event_code,
   output logic [3:0]                 rsp_keys_stable,
   output logic                       rsp_activity,
   output logic                       rsp_clean_request,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type    cfg_ff;
   result_type step_result;
   result_type out_ff;
   result_type skid_ff;
   logic       out_valid_ff;
   logic       skid_valid_ff;
   logic       accept;
   logic       out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_start       <= RAMP_START_RESET;
         cfg_ff.ramp_end         <= RAMP_END_RESET;
         cfg_ff.ramp_step        <= RAMP_STEP_RESET;
         cfg_ff.debounce_periods <= DEBOUNCE_PERIODS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_RAMP_START:       cfg_ff.ramp_start       <= csr_write_data;
            REG_RAMP_END:         cfg_ff.ramp_end         <= csr_write_data;
            REG_RAMP_STEP:        cfg_ff.ramp_step        <= csr_write_data;
            REG_DEBOUNCE_PERIODS: cfg_ff.debounce_periods <= csr_write_data;
            default: ;
         endcase
      end
   end

   kda_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step_en   (accept),
      .pin_level (req_pin_level),
      .cfg       (cfg_ff),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : step_result;
      end
      if (!out_free && accept) begin
         skid_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_written = out_ff.event_written;
   assign rsp_event_code    = out_ff.event_code;
   assign rsp_keys_stable   = out_ff.keys_stable;
   assign rsp_activity      = out_ff.activity;
   assign rsp_clean_request = out_ff.clean_request;

endmodule

FILE: src/kda_checker.sv
// Port-level checks for key_debounce_autorepeat, bound to the top level.
// Depends on kda_pkg for event codes.
module kda_checker import kda_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_event_written,
   input logic [7:0] rsp_event_code,
   input logic       rsp_clean_request
);

   a_reset_empties : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   a_code_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_event_written |-> rsp_event_code == 8'd0)
      else $error("event code nonzero without event write");

   a_clean_is_k : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clean_request |-> rsp_event_written && rsp_event_code == CODE_CLEAN)
      else $error("clean request without clean key event");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_code))
      else $error("stalled result beat changed");

endmodule

bind key_debounce_autorepeat kda_checker u_kda_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_event_written (rsp_event_written),
   .rsp_event_code    (rsp_event_code),
   .rsp_clean_request (rsp_clean_request)
);

FILE: sim/tb_key_debounce_autorepeat.sv
// Testbench for key_debounce_autorepeat: drives tick beats and register writes,
// predicts every result beat with a scoreboard class and checks it on arrival.
// Depends on kda_pkg and the key_debounce_autorepeat RTL only.
module tb_key_debounce_autorepeat;
   import kda_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned HOLD_OFF_CYCLES = 60;
   localparam int unsigned MAX_HOLD_SCANS  = 50;
   localparam int unsigned REPORT_LIMIT    = 10;

   localparam logic [3:0] PAT_CLEAN_KEY = 4'hE;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNMAPPED_FIRST = 8'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNMAPPED_LAST  = 8'hFF;

   class tick_scoreboard;
      logic [7:0] start_ivl, floor_ivl, step_ivl, settle_periods;
      logic [3:0] shifter, seen_pattern, held_pattern;
      logic [2:0] phase_cnt;
      logic [7:0] settle_cnt, repeat_cnt, repeat_ivl;
      logic       fn_held;
      result_type expected_q[$];
      int         mismatches, checked, key_events, long_presses, clean_events;

      function new();
         reset_state();
         mismatches   = 0;
         checked      = 0;
         key_events   = 0;
         long_presses = 0;
         clean_events = 0;
      endfunction

      function void reset_state();
         start_ivl      = RAMP_START_RESET;
         floor_ivl      = RAMP_END_RESET;
         step_ivl       = RAMP_STEP_RESET;
         settle_periods = DEBOUNCE_PERIODS_RESET;
         shifter        = '0;
         phase_cnt      = PHASE_START;
         seen_pattern   = '0;
         settle_cnt     = '0;
         held_pattern   = PAT_NO_KEY;
         repeat_cnt     = RAMP_START_RESET;
         repeat_ivl     = RAMP_START_RESET;
         fn_held        = 1'b0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [7:0] value);
         case (index)
            REG_RAMP_START:       start_ivl = value;
            REG_RAMP_END:         floor_ivl = value;
            REG_RAMP_STEP:        step_ivl = value;
            REG_DEBOUNCE_PERIODS: settle_periods = value;
            default: ;
         endcase
      endfunction

      function void note_tick(logic pin);
         result_type r;
         logic [3:0] press_mask;
         logic [8:0] grown;
         r = '0;
         shifter   = {pin, shifter[3:1]};
         phase_cnt = phase_cnt - 3'd1;
         if (phase_cnt == 3'd0) begin
            phase_cnt = PHASE_START;
            if (shifter != seen_pattern) begin
               settle_cnt   = settle_periods;
               seen_pattern = shifter;
            end
            if (settle_cnt != 8'd0) begin
               settle_cnt = settle_cnt - 8'd1;
               if (settle_cnt == 8'd0) begin
                  if (shifter != PAT_NO_KEY || held_pattern == PAT_FN_KEY) begin
                     press_mask   = (held_pattern ^ shifter) & (held_pattern ^ PAT_RELEASE);
                     r.event_code = {4'h0, press_mask};
                     if (press_mask == EDGE_DOWN) r.event_code = CODE_DOWN;
                     else if (press_mask == EDGE_UP) r.event_code = CODE_UP;
                     else if (press_mask == EDGE_RELEASE && !fn_held) r.event_code = CODE_RELEASE;
                     else if (press_mask == EDGE_CLEAN) begin
                        r.event_code    = CODE_CLEAN;
                        r.clean_request = 1'b1;
                     end
                     r.event_written = 1'b1;
                  end
                  if (held_pattern == PAT_NO_KEY) fn_held = 1'b0;
                  if (held_pattern != shifter) repeat_cnt = start_ivl;
                  held_pattern = shifter;
                  r.activity   = 1'b1;
               end
            end
            if (repeat_cnt > floor_ivl) begin
               repeat_cnt = repeat_cnt - 8'd1;
            end else begin
               repeat_cnt = repeat_ivl;
               if (held_pattern == PAT_NO_KEY) begin
                  if (repeat_ivl < start_ivl) begin
                     grown      = {1'b0, repeat_ivl} + {1'b0, step_ivl};
                     repeat_ivl = grown[8] ? 8'hFF : grown[7:0];
                  end
               end else begin
                  if (repeat_ivl > floor_ivl)
                     repeat_ivl = (repeat_ivl >= step_ivl) ? repeat_ivl - step_ivl : 8'd0;
                  if (held_pattern == PAT_DOWN_KEY) begin
                     r.event_code    = CODE_DOWN;
                     r.event_written = 1'b1;
                  end
                  if (held_pattern == PAT_UP_KEY) begin
                     r.event_code    = CODE_UP;
                     r.event_written = 1'b1;
                  end
                  if (held_pattern == PAT_FN_KEY &&
                      int'(repeat_ivl) < (int'(start_ivl) * 3) / 4) begin
                     r.event_code    = CODE_FUNC;
                     r.event_written = 1'b1;
                     repeat_ivl      = start_ivl;
                     fn_held         = 1'b1;
                     long_presses++;
                  end
                  r.activity = 1'b1;
               end
            end
         end
         r.keys_stable = held_pattern;
         if (r.event_written) key_events++;
         if (r.clean_request) clean_events++;
         expected_q.push_back(r);
      endfunction

      function void check_result(result_type got);
         result_type exp;
         checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"result beat with no tick pending: ",
                         "written=%0b code=%h keys=%h act=%0b clean=%0b"},
                        got.event_written, got.event_code, got.keys_stable,
                        got.activity, got.clean_request);
            return;
         end
         exp = expected_q.pop_front();
         if (got !== exp) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"result %0d mismatch: ",
                         "exp written=%0b code=%h keys=%h act=%0b clean=%0b, ",
                         "got written=%0b code=%h keys=%h act=%0b clean=%0b"},
                        checked, exp.event_written, exp.event_code, exp.keys_stable,
                        exp.activity, exp.clean_request, got.event_written,
                        got.event_code, got.keys_stable, got.activity, got.clean_request);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   logic                       req_pin_level    = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   logic                       rsp_event_written;
   logic [7:0]                 rsp_event_code;
   logic [3:0]                 rsp_keys_stable;
   logic                       rsp_activity;
   logic                       rsp_clean_request;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data   = '0;

   tick_scoreboard sb;
   int unsigned    cycle_count      = 0;
   int             ticks_sent       = 0;
   int             settings_applied = 0;
   int             tick_gap_pct     = 0;
   int             rsp_gap_pct      = 0;
   bit             hold_off_req     = 1'b0;

   key_debounce_autorepeat i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pin_level     (req_pin_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_written (rsp_event_written),
      .rsp_event_code    (rsp_event_code),
      .rsp_keys_stable   (rsp_keys_stable),
      .rsp_activity      (rsp_activity),
      .rsp_clean_request (rsp_clean_request),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result({rsp_event_written, rsp_event_code, rsp_keys_stable,
                             rsp_activity, rsp_clean_request});
         if (req_valid && !req_stall)
            sb.note_tick(req_pin_level);
      end
   end

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall    <= 1'b0;
            hold_off_req = 1'b0;
         end else if (rsp_gap_pct > 0 && $urandom_range(0, 99) < rsp_gap_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_tick(input logic pin);
      if (tick_gap_pct > 0 && $urandom_range(0, 99) < tick_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pin_level <= pin;
      do @(posedge clock); while (req_stall);
      ticks_sent++;
   endtask

   // pad with noise up to a scan boundary, then present the pattern once per scan
   task automatic hold_pattern(input logic [3:0] pattern, input int scans);
      while (ticks_sent % 4 != 0) send_tick(1'($urandom_range(0, 1)));
      repeat (scans)
         for (int b = 0; b < 4; b++) send_tick(pattern[b]);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index, input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      sb.write_reg(index, value);
   endtask

   task automatic set_config(input logic [7:0] start_v, end_v, step_v, settle_v);
      write_csr(REG_RAMP_START, start_v);
      write_csr(REG_RAMP_END, end_v);
      write_csr(REG_RAMP_STEP, step_v);
      write_csr(REG_DEBOUNCE_PERIODS, settle_v);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   function automatic logic [3:0] pick_pattern();
      case ($urandom_range(0, 9))
         0, 1:    return PAT_NO_KEY;
         2, 3:    return PAT_DOWN_KEY;
         4:       return PAT_UP_KEY;
         5, 6:    return PAT_FN_KEY;
         7:       return PAT_CLEAN_KEY;
         default: return 4'($urandom_range(0, 15));
      endcase
   endfunction

   task automatic run_phase(input logic [7:0] start_v, end_v, step_v, settle_v,
                            input int budget, input int idle_pct, input bit squeeze);
      int first_tick;
      int scans;
      drain_results();
      set_config(start_v, end_v, step_v, settle_v);
      tick_gap_pct = idle_pct;
      rsp_gap_pct  = idle_pct;
      if (squeeze) hold_off_req = 1'b1;
      first_tick = ticks_sent;
      while (ticks_sent - first_tick < budget) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 7)) send_tick(1'($urandom_range(0, 1)));
         end else begin
            if ($urandom_range(0, 4) == 0)
               scans = int'(settle_v) + $urandom_range(4, int'(start_v) + 12);
            else
               scans = int'(settle_v) + $urandom_range(0, 3);
            if (scans > MAX_HOLD_SCANS) scans = MAX_HOLD_SCANS;
            if (scans < 1) scans = 1;
            hold_pattern(pick_pattern(), scans);
         end
      end
   endtask

   initial begin : stimulus
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one scan per pattern: down, up, clean, fn press, fn release, all keys
      drain_results();
      set_config(8'd6, 8'd0, 8'd1, 8'd1);
      hold_pattern(PAT_DOWN_KEY, 1);
      hold_pattern(PAT_UP_KEY, 1);
      hold_pattern(PAT_CLEAN_KEY, 1);
      hold_pattern(PAT_FN_KEY, 1);
      hold_pattern(PAT_NO_KEY, 1);
      hold_pattern(4'h0, 1);

      run_phase(RAMP_START_RESET, RAMP_END_RESET, RAMP_STEP_RESET, DEBOUNCE_PERIODS_RESET,
                200, 10, 1'b0);
      run_phase(8'd12, 8'd2, 8'd3, 8'd2, 150, 20, 1'b1);
      run_phase(8'd10, 8'd0, 8'd9, 8'd1, 100, 0, 1'b0);
      hold_pattern(PAT_DOWN_KEY, 30);
      run_phase(8'd255, 8'd250, 8'd250, 8'd1, 40, 15, 1'b0);
      hold_pattern(PAT_NO_KEY, 12);
      run_phase(8'd1, 8'd0, 8'd255, 8'd1, 150, 25, 1'b0);
      run_phase(8'd255, 8'd255, 8'd255, 8'd255, 40, 10, 1'b0);

      // zero step and zero debounce, plus writes to unmapped indexes
      drain_results();
      write_csr(REG_UNMAPPED_FIRST, 8'hAA);
      write_csr(REG_UNMAPPED_LAST, 8'h00);
      csr_write_enable <= 1'b0;
      run_phase(8'd8, 8'd0, 8'd0, 8'd0, 100, 10, 1'b0);

      repeat (4)
         run_phase(8'($urandom_range(1, 40)), 8'($urandom_range(0, 8)),
                   8'($urandom_range(1, 16)), 8'($urandom_range(1, 4)),
                   80, 5 * $urandom_range(0, 5), 1'b0);
      run_phase(8'd20, 8'd4, 8'd2, 8'd2, 150, 0, 1'b0);

      drain_results();
      repeat (4) @(posedge clock);
      $display("covered %0d tick beats over %0d register settings, %0d result beats checked",
               ticks_sent, settings_applied, sb.checked);
      $display("key events %0d, function long presses %0d, clean requests %0d, mismatches %0d",
               sb.key_events, sb.long_presses, sb.clean_events, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
